// File: sv/sbft_pkg.sv
// ----------------------------------------------------------------------------
// sbft_pkg
// shared types and constants of the spike burst fraction tracker
// ----------------------------------------------------------------------------
`default_nettype none

package sbft_pkg;

  localparam int unsigned TS_W        = 32;
  localparam int unsigned PROBE_W     = 3;
  localparam int unsigned CLUSTER_W   = 4;
  localparam int unsigned CNT_FIELD_W = 24;
  localparam int unsigned FRAC_FBITS  = 16;
  localparam int unsigned FRAC_W      = FRAC_FBITS + 1;
  localparam int unsigned DIV_STEPS   = FRAC_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [TS_W-1:0] ISI_LIMIT_RESET = 32'd100;

  typedef struct packed {
    logic                 is_spike_record;
    logic [PROBE_W-1:0]   probe_index;
    logic [CLUSTER_W-1:0] cluster_index;
    logic [TS_W-1:0]      event_time;
  } in_item_t;

  typedef struct packed {
    logic [PROBE_W-1:0]     channel_probe;
    logic [CLUSTER_W-1:0]   channel_cluster;
    logic [CNT_FIELD_W-1:0] total_spikes;
    logic [CNT_FIELD_W-1:0] burst_spikes;
    logic                   in_burst;
    logic [FRAC_W-1:0]      burst_fraction;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_HOLD
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_we;
    logic capture;
    logic update;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_ok;
    logic clear_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/sbft_ctrl.sv
// ----------------------------------------------------------------------------
// sbft_ctrl
// sequencer: table clear, item capture, update, divide and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module sbft_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire sbft_pkg::dp_sts_t sts_i,
  output sbft_pkg::dp_cmd_t     cmd_o
);
  import sbft_pkg::*;

  ctl_state_e           state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // ignored records are taken here and leave no trace
        if (in_valid_i && sts_i.item_ok) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        div_cnt_d    = '0;
        state_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_HOLD;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      ST_HOLD: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: sv/sbft_dp.sv
// ----------------------------------------------------------------------------
// sbft_dp
// channel table, burst classification, saturating counts, fraction divider
// ----------------------------------------------------------------------------
`default_nettype none

module sbft_dp #(
  parameter int unsigned NUM_PROBES         = 8,
  parameter int unsigned CLUSTERS_PER_PROBE = 16,
  parameter int unsigned COUNT_BITS         = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sbft_pkg::TS_W-1:0]    cfg_data_i,
  input  wire sbft_pkg::in_item_t           in_data_i,
  input  wire sbft_pkg::dp_cmd_t            cmd_i,
  output sbft_pkg::dp_sts_t                 sts_o,
  output sbft_pkg::out_item_t               out_data_o
);
  import sbft_pkg::*;

  localparam int unsigned CHANNELS = NUM_PROBES * CLUSTERS_PER_PROBE;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [TS_W-1:0]       last_time;
    logic                  last_burst;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] burst;
  } entry_t;

  function automatic logic [CNT_FIELD_W-1:0] to_field(input logic [COUNT_BITS-1:0] x);
    logic [CNT_FIELD_W+COUNT_BITS-1:0] ext;
    ext = {(CNT_FIELD_W)'(0), x};
    return ext[CNT_FIELD_W-1:0];
  endfunction

  // isi limit register
  logic [TS_W-1:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ISI_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // channel decode
  logic [31:0]     ch_full;
  logic [CH_W-1:0] ch_idx;
  assign ch_full = 32'(in_data_i.probe_index) * 32'(CLUSTERS_PER_PROBE)
                 + 32'(in_data_i.cluster_index);
  assign ch_idx  = ch_full[CH_W-1:0];

  assign sts_o.item_ok = in_data_i.is_spike_record
                       && (32'(in_data_i.probe_index) < 32'(NUM_PROBES))
                       && (32'(in_data_i.cluster_index) < 32'(CLUSTERS_PER_PROBE));

  // clear sweep address
  logic [CH_W-1:0] clr_addr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end
  assign sts_o.clear_last = (clr_addr_q == CH_W'(CHANNELS - 1));

  // captured item
  logic [CH_W-1:0]      ch_q;
  logic [PROBE_W-1:0]   probe_q;
  logic [CLUSTER_W-1:0] cluster_q;
  logic [TS_W-1:0]      ts_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q      <= ch_idx;
      probe_q   <= in_data_i.probe_index;
      cluster_q <= in_data_i.cluster_index;
      ts_q      <= in_data_i.event_time;
    end
  end

  // channel table
  entry_t mem [CHANNELS];
  entry_t rd_q;
  entry_t wr_entry;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_q <= mem[ch_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      mem[clr_addr_q] <= '0;
    end else if (cmd_i.update) begin
      mem[ch_q] <= wr_entry;
    end
  end

  // burst classification and count update
  logic                  had_prev;
  logic [TS_W-1:0]       interval;
  logic                  burst;
  logic [COUNT_BITS-1:0] total_new;
  logic [COUNT_BITS:0]   burst_sum;
  logic [COUNT_BITS-1:0] burst_new;

  always_comb begin
    had_prev  = (rd_q.total != '0);
    interval  = ts_q - rd_q.last_time;
    burst     = had_prev && (interval <= limit_q);
    total_new = (rd_q.total == CNT_MAX) ? CNT_MAX : rd_q.total + 1'b1;
    // opening a burst also counts the spike before it
    burst_sum = {1'b0, rd_q.burst}
              + (rd_q.last_burst ? (COUNT_BITS+1)'(1) : (COUNT_BITS+1)'(2));
    if (!burst) begin
      burst_new = rd_q.burst;
    end else if (burst_sum > {1'b0, CNT_MAX}) begin
      burst_new = CNT_MAX;
    end else begin
      burst_new = burst_sum[COUNT_BITS-1:0];
    end
    wr_entry.last_time  = ts_q;
    wr_entry.last_burst = burst;
    wr_entry.total      = total_new;
    wr_entry.burst      = burst_new;
  end

  // restoring divider, one quotient bit a step, msb first
  logic [COUNT_BITS-1:0] total_q, burst_q, den_q;
  logic                  in_burst_q;
  logic [COUNT_BITS:0]   rem_q;
  logic [FRAC_W-1:0]     quo_q;
  logic                  rem_ge;
  logic [COUNT_BITS:0]   rem_diff, rem_next;

  assign rem_ge   = (rem_q >= {1'b0, den_q});
  assign rem_diff = rem_q - {1'b0, den_q};
  assign rem_next = rem_ge ? rem_diff : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      total_q    <= total_new;
      burst_q    <= burst_new;
      in_burst_q <= burst;
      den_q      <= total_new;
      rem_q      <= {1'b0, burst_new};
      quo_q      <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= {rem_next[COUNT_BITS-1:0], 1'b0};
      quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
    end
  end

  // output register
  out_item_t out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.channel_probe   <= probe_q;
      out_q.channel_cluster <= cluster_q;
      out_q.total_spikes    <= to_field(total_q);
      out_q.burst_spikes    <= to_field(burst_q);
      out_q.in_burst        <= in_burst_q;
      out_q.burst_fraction  <= quo_q;
    end
  end
  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: sv/spike_burst_fraction_tracker_core.sv
// ----------------------------------------------------------------------------
// spike_burst_fraction_tracker_core
// per-channel isi burst detection with saturating counts and a q1.16
// burst fraction for every in-range spike event
// ----------------------------------------------------------------------------
//
//   port group   direction   beat contents
//   cfg_*        in          burst isi limit, 32 bits
//   in_*         in          in_item_t: spike flag, probe, cluster, timestamp
//   out_*        out         out_item_t: channel, counts, burst flag, fraction
//
// after reset the channel table is swept to zero, one entry per cycle,
// while in_ready_o is low
// a spike beat goes through capture and table read, update and write back,
// 17 restoring divider steps for the fraction, then the output register load
// non-spike or out-of-range beats are taken and give no result
// a finished result waits in the output register while out_ready_i is low;
// the next beat is already accepted and stalls only at its own hand-off
//
`default_nettype none

module spike_burst_fraction_tracker_core #(
  parameter int unsigned NUM_PROBES         = 8,
  parameter int unsigned CLUSTERS_PER_PROBE = 16,
  parameter int unsigned COUNT_BITS         = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration write channel
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [sbft_pkg::TS_W-1:0]  cfg_data_i,
  // spike events
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire sbft_pkg::in_item_t         in_data_i,
  // per-spike results
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output sbft_pkg::out_item_t             out_data_o
);
  import sbft_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // the limit register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  sbft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sbft_dp #(
    .NUM_PROBES         (NUM_PROBES),
    .CLUSTERS_PER_PROBE (CLUSTERS_PER_PROBE),
    .COUNT_BITS         (COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// File: sv/sbft_checker.sv
// ----------------------------------------------------------------------------
// sbft_checker
// port-level checks of the spike burst fraction tracker
// ----------------------------------------------------------------------------
`default_nettype none

module sbft_checker #(
  parameter int unsigned COUNT_BITS = 24
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire sbft_pkg::in_item_t  in_data_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire sbft_pkg::out_item_t out_data_o
);
  import sbft_pkg::*;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_FBITS;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // fraction never above one
  a_frac_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.burst_fraction <= FRAC_ONE)
    else $error("burst fraction above one");

  // all spikes in bursts gives exactly one
  a_frac_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (COUNT_BITS <= CNT_FIELD_W) && (out_data_o.total_spikes != '0)
      && (out_data_o.burst_spikes == out_data_o.total_spikes)
      |-> out_data_o.burst_fraction == FRAC_ONE)
    else $error("full burst fraction not one");

  // a skipped record leaves the block free
  a_skip_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.is_spike_record |=> in_ready_o)
    else $error("non-spike beat made the block busy");

endmodule

bind spike_burst_fraction_tracker_core sbft_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_sbft_checker (.*);

`default_nettype wire

// File: test/spike_burst_fraction_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// spike_burst_fraction_tracker_core_tb
// drives spike beats with random gaps and random result stalls, predicts
// each result from its own per-channel table and checks every output beat
// ----------------------------------------------------------------------------
`default_nettype none

module spike_burst_fraction_tracker_core_tb;
  import sbft_pkg::*;

  localparam int unsigned NUM_PROBES         = 8;
  localparam int unsigned CLUSTERS_PER_PROBE = 16;
  localparam int unsigned COUNT_BITS         = 24;
  localparam int unsigned CHANNELS           = NUM_PROBES * CLUSTERS_PER_PROBE;
  localparam int unsigned MAX_WAIT           = 11;
  localparam int unsigned SETTLE_CYCLES      = 40;
  localparam int unsigned WATCHDOG_LIMIT     = 3000;
  localparam int unsigned SPIKES_PER_PHASE   = 196;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [FRAC_W-1:0]     FRAC_ONE  = FRAC_W'(1) << FRAC_FBITS;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [TS_W-1:0] cfg_data  = '0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  in_item_t        in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;

  // stimulus side
  in_item_t        spike_beats [$];
  logic [TS_W-1:0] stim_time [CHANNELS];
  logic [TS_W-1:0] stim_limit = ISI_LIMIT_RESET;
  bit              no_idle    = 1'b0;

  // handshake bookkeeping between monitor and drivers
  bit          in_taken  = 1'b0;
  bit          out_taken = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned out_stall = 0;

  // predicted channel table and the burst limit it runs with
  logic [TS_W-1:0]       isi_limit = ISI_LIMIT_RESET;
  logic [TS_W-1:0]       last_time [CHANNELS];
  logic                  last_burst [CHANNELS];
  logic [COUNT_BITS-1:0] total_cnt [CHANNELS];
  logic [COUNT_BITS-1:0] burst_cnt [CHANNELS];
  out_item_t             fraction_q [$];

  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;

  spike_burst_fraction_tracker_core #(
    .NUM_PROBES         (NUM_PROBES),
    .CLUSTERS_PER_PROBE (CLUSTERS_PER_PROBE),
    .COUNT_BITS         (COUNT_BITS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(MAX_WAIT, 0);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input int unsigned b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + b[COUNT_BITS:0];
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // updates the channel table for one beat; returns 1 when a result is due
  function automatic bit track_spike(input in_item_t beat, output out_item_t res);
    int unsigned     ch;
    logic [TS_W-1:0] isi;
    logic            had_prev;
    logic            burst;
    logic [63:0]     quo;
    res = '0;
    if (!beat.is_spike_record) return 1'b0;
    if (beat.probe_index >= NUM_PROBES || beat.cluster_index >= CLUSTERS_PER_PROBE)
      return 1'b0;
    ch = beat.probe_index * CLUSTERS_PER_PROBE + beat.cluster_index;

    had_prev      = total_cnt[ch] != '0;
    total_cnt[ch] = sat_add(total_cnt[ch], 1);
    // interval wraps modulo 2^32
    isi   = beat.event_time - last_time[ch];
    burst = had_prev && (isi <= isi_limit);
    if (burst) begin
      // opening a burst pulls the previous spike in as well
      burst_cnt[ch]  = sat_add(burst_cnt[ch], last_burst[ch] ? 1 : 2);
      last_burst[ch] = 1'b1;
    end else begin
      last_burst[ch] = 1'b0;
    end
    last_time[ch] = beat.event_time;

    quo = (64'(burst_cnt[ch]) << FRAC_FBITS) / 64'(total_cnt[ch]);
    res.channel_probe   = beat.probe_index;
    res.channel_cluster = beat.cluster_index;
    res.total_spikes    = total_cnt[ch];
    res.burst_spikes    = burst_cnt[ch];
    res.in_burst        = burst;
    res.burst_fraction  = (quo > 64'(FRAC_ONE)) ? FRAC_ONE : quo[FRAC_W-1:0];
    return 1'b1;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // spike beat driver, changes on the falling edge
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap   = draw_wait();
      end
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (spike_beats.size() > 0) begin
        in_data  <= spike_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, fresh stall after every result beat
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_stall = draw_wait();
    end
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predicts on accepted spike beats, checks result beats, watchdog
  always @(posedge clk) begin
    out_item_t want;
    bit        busy;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        isi_limit = cfg_data;
        busy      = 1'b1;
      end
      if (in_valid && in_ready) begin
        busy     = 1'b1;
        in_taken = 1'b1;
        if (track_spike(in_data, want)) fraction_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        busy      = 1'b1;
        out_taken = 1'b1;
        if (fraction_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %0h", $time, out_data);
          mismatch_cnt++;
        end else begin
          want = fraction_q.pop_front();
          report_field("channel_probe", 32'(want.channel_probe),
                       32'(out_data.channel_probe));
          report_field("channel_cluster", 32'(want.channel_cluster),
                       32'(out_data.channel_cluster));
          report_field("total_spikes", 32'(want.total_spikes),
                       32'(out_data.total_spikes));
          report_field("burst_spikes", 32'(want.burst_spikes),
                       32'(out_data.burst_spikes));
          report_field("in_burst", 32'(want.in_burst), 32'(out_data.in_burst));
          report_field("burst_fraction", 32'(want.burst_fraction),
                       32'(out_data.burst_fraction));
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("spike_burst_fraction_tracker_core test failed");
        $finish;
      end
    end
  end

  task automatic add_beat(input logic spike, input logic [PROBE_W-1:0] probe,
                          input logic [CLUSTER_W-1:0] cluster, input logic [TS_W-1:0] ts);
    in_item_t beat;
    beat.is_spike_record = spike;
    beat.probe_index     = probe;
    beat.cluster_index   = cluster;
    beat.event_time      = ts;
    spike_beats.push_back(beat);
  endtask

  // block is idle once every beat is taken and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (spike_beats.size() != 0 || in_valid || fraction_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_isi_limit(input logic [TS_W-1:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    stim_limit = value;
  endtask

  // spike trains on a few hot channels with intervals around the limit,
  // some spread over all channels, plus ignored records as noise
  task automatic queue_random_phase(input int unsigned spikes);
    int unsigned     hot [4];
    int unsigned     ch;
    int unsigned     made;
    logic [TS_W-1:0] step;
    made = 0;
    foreach (hot[k]) hot[k] = $urandom_range(CHANNELS - 1, 0);
    while (made < spikes) begin
      if ($urandom_range(9, 0) == 0) begin
        add_beat(1'b0, PROBE_W'($urandom_range(7, 0)), CLUSTER_W'($urandom_range(15, 0)),
                 $urandom);
      end else begin
        ch = ($urandom_range(3, 0) != 0) ? hot[$urandom_range(3, 0)]
                                         : $urandom_range(CHANNELS - 1, 0);
        case ($urandom_range(9, 0)) inside
          0:       step = '0;
          1, 2:    step = stim_limit;
          3:       step = stim_limit + 1;
          4, 5:    step = $urandom_range(stim_limit, 0);
          6:       step = stim_limit + 1 + $urandom_range(1000, 0);
          7:       step = $urandom;
          default: step = $urandom_range(50, 0);
        endcase
        stim_time[ch] += step;
        add_beat(1'b1, PROBE_W'(ch / CLUSTERS_PER_PROBE), CLUSTER_W'(ch % CLUSTERS_PER_PROBE),
                 stim_time[ch]);
        made++;
      end
    end
  endtask

  initial begin
    logic [TS_W-1:0] limits [5];
    for (int i = 0; i < CHANNELS; i++) begin
      last_time[i]  = '0;
      last_burst[i] = 1'b0;
      total_cnt[i]  = '0;
      burst_cnt[i]  = '0;
      stim_time[i]  = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset limit of 100 ticks
    add_beat(1'b0, 3'd7, 4'd15, 32'hFFFF_FFFF);   // ignored record, all ones
    add_beat(1'b0, 3'd0, 4'd0, 32'h0);            // ignored record, all zeros
    add_beat(1'b1, 3'd0, 4'd0, 32'd0);            // first spike on the channel
    add_beat(1'b1, 3'd0, 4'd0, 32'd100);          // interval at the limit opens a burst
    add_beat(1'b1, 3'd0, 4'd0, 32'd200);          // burst goes on
    add_beat(1'b0, 3'd0, 4'd0, 32'd250);          // ignored, table must not move
    add_beat(1'b1, 3'd0, 4'd0, 32'd301);          // one past the limit
    add_beat(1'b1, 3'd0, 4'd0, 32'd301);          // zero interval
    add_beat(1'b1, 3'd3, 4'd6, 32'd50);           // first spike, close to stored zero
    add_beat(1'b1, 3'd3, 4'd6, 32'd151);
    add_beat(1'b1, 3'd3, 4'd6, 32'd251);
    add_beat(1'b1, 3'd7, 4'd15, 32'hFFFF_FFF0);
    add_beat(1'b1, 3'd7, 4'd15, 32'h0000_0010);   // timestamp wrap, short interval
    add_beat(1'b1, 3'd7, 4'd15, 32'hFFFF_FFFF);   // wrap the other way, huge interval
    add_beat(1'b1, 3'd5, 4'd10, 32'hFFFF_FFFF);
    add_beat(1'b1, 3'd5, 4'd10, 32'h0000_0063);   // wrap landing right on the limit
    add_beat(1'b1, 3'd0, 4'd15, 32'd12345);
    add_beat(1'b1, 3'd7, 4'd0, 32'd12400);
    add_beat(1'b1, 3'd0, 4'd15, 32'd12400);
    wait_drained();

    limits[0] = '0;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'd1000;
    limits[3] = $urandom_range(5000, 1);
    limits[4] = ISI_LIMIT_RESET;
    foreach (limits[p]) begin
      write_isi_limit(limits[p]);
      no_idle = (p % 3 == 1);
      queue_random_phase(SPIKES_PER_PHASE);
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("spike_burst_fraction_tracker_core test passed");
    end else begin
      $display("spike_burst_fraction_tracker_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/sbft_pkg.sv
sv/sbft_ctrl.sv
sv/sbft_dp.sv
sv/spike_burst_fraction_tracker_core.sv
sv/sbft_checker.sv
test/spike_burst_fraction_tracker_core_tb.sv
